// ===== src/sstc_pkg.sv =====
// Shared types and constants of the serial settable time-of-day clock.
// Used by the input stage, the time core, the output stage and the top level.
package sstc_pkg;

    // Widths of the item fields.
    localparam int PERIOD_W = 10;
    localparam int CHAR_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TENTH_W  = 4;
    localparam int MASK_W   = 4;
    localparam int ENTRY_W  = 8;
    localparam int STAGE_W  = 2;
    localparam int OUT_DATA_W = 32;

    // Reset value of the period register.
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 10'd100;

    // Item kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    // Characters that the entry logic reacts to.
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'd58;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    // Top values of the time counters.
    localparam logic [TENTH_W-1:0] TENTH_TOP = 4'd9;
    localparam logic [SEC_W-1:0]   SEC_TOP   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_TOP   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_TOP  = 5'd23;

    // Entry stages.
    localparam logic [STAGE_W-1:0] STAGE_HOUR = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_MIN  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SEC  = 2'd2;

    // Mask bits.
    localparam logic [MASK_W-1:0] MASK_ALL = 4'hF;

    // One input item.
    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
    } in_item_t;

    // One result item; the last member sits in the lowest bits.
    typedef struct packed {
        logic               time_loaded;
        logic               clock_running;
        logic [MASK_W-1:0]  changed_mask;
        logic [TENTH_W-1:0] tenths;
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HOUR_W-1:0]  hours;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== src/sstc_in_stage.sv =====
// Input register of the time-of-day clock.
// Holds one accepted item until the core takes it; depends on sstc_pkg.
module sstc_in_stage
    import sstc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    // A new item enters when the register is empty or drains this cycle.
    assign s_tready = !vld_reg || take;
    assign vld_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : vld_reg);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// ===== src/sstc_core.sv =====
// Time core: tick phase, time counters and serial time entry.
// Computes the result of the held item from the state; depends on sstc_pkg.
module sstc_core
    import sstc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic                fire,
    input  in_item_t            item,
    output result_t             result
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] phase_reg,  phase_next;
    logic [TENTH_W-1:0]  tenth_reg,  tenth_next;
    logic [SEC_W-1:0]    sec_reg,    sec_next;
    logic [MIN_W-1:0]    min_reg,    min_next;
    logic [HOUR_W-1:0]   hour_reg,   hour_next;
    logic                run_reg,    run_next;
    logic [STAGE_W-1:0]  stage_reg,  stage_next;
    logic [ENTRY_W-1:0]  hent_reg,   hent_next;
    logic [ENTRY_W-1:0]  ment_reg,   ment_next;
    logic [ENTRY_W-1:0]  sent_reg,   sent_next;

    logic [PERIOD_W:0]   phase_inc;
    logic                phase_wrap;
    logic                is_digit;
    logic [ENTRY_W-1:0]  digit;
    logic [ENTRY_W-1:0]  sel_entry;
    logic [ENTRY_W-1:0]  sel_entry_new;
    logic [MASK_W-1:0]   mask;
    logic                loaded;

    // Period register; the user must write it only while the block is idle, as the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= RESET_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    // Shared decode of the phase step and of a digit.
    assign phase_inc  = {1'b0, phase_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign phase_wrap = (phase_inc >= {1'b0, period_reg});
    assign is_digit   = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    assign digit      = item.char_code - CHAR_ZERO;

    // Entry field picked by the stage, and its value after one more digit.
    always_comb
    begin
        case (stage_reg)
            STAGE_HOUR: sel_entry = hent_reg;
            STAGE_MIN:  sel_entry = ment_reg;
            default:    sel_entry = sent_reg;
        endcase
    end
    assign sel_entry_new = {sel_entry[ENTRY_W-4:0], 3'b000}
                         + {sel_entry[ENTRY_W-2:0], 1'b0} + digit;

    // Next state and result of the held item.
    always_comb
    begin
        phase_next = phase_reg;
        tenth_next = tenth_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        run_next   = run_reg;
        stage_next = stage_reg;
        hent_next  = hent_reg;
        ment_next  = ment_reg;
        sent_next  = sent_reg;
        mask       = '0;
        loaded     = 1'b0;

        if (item.req_type == REQ_TICK)
        begin
            // The phase runs even while the clock is stopped.
            phase_next = phase_wrap ? '0 : phase_inc[PERIOD_W-1:0];
            if (phase_wrap && run_reg)
            begin
                mask[0] = 1'b1;
                if (tenth_reg < TENTH_TOP)
                begin
                    tenth_next = tenth_reg + 1'b1;
                end
                else
                begin
                    tenth_next = '0;
                    mask[1]    = 1'b1;
                    if (sec_reg < SEC_TOP)
                    begin
                        sec_next = sec_reg + 1'b1;
                    end
                    else
                    begin
                        sec_next = '0;
                        mask[2]  = 1'b1;
                        if (min_reg < MIN_TOP)
                        begin
                            min_next = min_reg + 1'b1;
                        end
                        else
                        begin
                            min_next  = '0;
                            mask[3]   = 1'b1;
                            hour_next = (hour_reg < HOUR_TOP) ? hour_reg + 1'b1 : '0;
                        end
                    end
                end
            end
        end
        else if (is_digit)
        begin
            // A digit stops the clock and extends the selected field.
            run_next = 1'b0;
            case (stage_reg)
                STAGE_HOUR: hent_next = sel_entry_new;
                STAGE_MIN:  ment_next = sel_entry_new;
                STAGE_SEC:  sent_next = sel_entry_new;
                default:    ;
            endcase
        end
        else if (item.char_code == CHAR_COLON)
        begin
            // A colon moves to the next field and clears it.
            case (stage_reg)
                STAGE_HOUR:
                begin
                    stage_next = STAGE_MIN;
                    ment_next  = '0;
                end
                STAGE_MIN:
                begin
                    stage_next = STAGE_SEC;
                    sent_next  = '0;
                end
                default:
                begin
                    stage_next = STAGE_HOUR;
                    hent_next  = '0;
                end
            endcase
        end
        else if (item.char_code == CHAR_CR)
        begin
            // Carriage return loads the clamped time and restarts the clock.
            tenth_next = '0;
            hour_next  = (hent_reg > {{(ENTRY_W-HOUR_W){1'b0}}, HOUR_TOP})
                       ? HOUR_TOP : hent_reg[HOUR_W-1:0];
            min_next   = (ment_reg > {{(ENTRY_W-MIN_W){1'b0}}, MIN_TOP})
                       ? MIN_TOP : ment_reg[MIN_W-1:0];
            sec_next   = (sent_reg > {{(ENTRY_W-SEC_W){1'b0}}, SEC_TOP})
                       ? SEC_TOP : sent_reg[SEC_W-1:0];
            hent_next  = '0;
            ment_next  = '0;
            sent_next  = '0;
            stage_next = STAGE_HOUR;
            run_next   = 1'b1;
            mask       = MASK_ALL;
            loaded     = 1'b1;
        end
    end

    // State registers, updated when the held item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            tenth_reg <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            run_reg   <= 1'b1;
            stage_reg <= STAGE_HOUR;
            hent_reg  <= '0;
            ment_reg  <= '0;
            sent_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tenth_reg <= tenth_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            run_reg   <= run_next;
            stage_reg <= stage_next;
            hent_reg  <= hent_next;
            ment_reg  <= ment_next;
            sent_reg  <= sent_next;
        end
    end

    // Result of the held item.
    always_comb
    begin
        result.time_loaded   = loaded;
        result.clock_running = run_next;
        result.changed_mask  = mask;
        result.tenths        = tenth_next;
        result.seconds       = sec_next;
        result.minutes       = min_next;
        result.hours         = hour_next;
    end

endmodule

// ===== src/sstc_out_stage.sv =====
// Output register of the time-of-day clock.
// Holds one result item until the sink takes it; depends on sstc_pkg.
module sstc_out_stage
    import sstc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // The slot is free when empty or when its item leaves this cycle.
    assign free     = !vld_reg || m_tready;
    assign vld_next = load ? 1'b1 : (m_tready ? 1'b0 : vld_reg);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_result = res_reg;

endmodule

// ===== src/serial_settable_time_of_day_clock.sv =====
// Top level of the serial settable time-of-day clock.
// Connects sstc_in_stage, sstc_core and sstc_out_stage; depends on sstc_pkg.

// Each input item is a millisecond tick or a received character; each gives
// exactly one result item with the time after it, a mask of changed counters,
// the run flag and a load flag. An item passes through an input register,
// the combinational logic of the time core and an output register; a result
// is offered once the output register holds it and can be taken when the
// sink is ready, and one item is accepted every cycle while the sink keeps
// taking results. The period register is written through cfg_wr_en and
// cfg_wr_data and must only change while no item is in flight.
module serial_settable_time_of_day_clock
    import sstc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PERIOD_W-1:0]   cfg_wr_data,     // ticks_per_tenth
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,         // char_code[7:0]
    input  logic                  s_tuser,         // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hours[4:0], minutes[10:5], seconds[16:11], tenths[20:17],
    // changed_mask[24:21], clock_running[25], time_loaded[26], zeros above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    result_t  result;
    result_t  m_result;

    assign s_item.req_type  = s_tuser;
    assign s_item.char_code = s_tdata;

    // The held item is processed when the output slot can take its result.
    assign fire = item_valid && out_free;

    sstc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sstc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .result      (result)
    );

    sstc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, m_result};

endmodule
